>>> src/acst_pkg.sv
// ----------------------------------------------------------------------------
// acst_pkg
// Shared constants for the AC-line synchronized TRIAC heater and motor
// controller: event codes, phase sequencer steps and timer reload values.
// ----------------------------------------------------------------------------
package acst_pkg;

    // Timing and window constants.
    localparam int WINDOW_PERIODS   = 16;
    localparam int GATE_PULSE_TICKS = 4;
    localparam int QUARTER_TICKS    = 40;
    localparam int IGNORE_TICKS     = 120;
    localparam int LOST_TICKS       = 200;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int DIR_W      = 2;
    localparam int STEP_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USED_W = 34;

    // Event codes carried in the input transaction's tuser.
    localparam logic [OP_W-1:0] OP_ZERO_CROSS = 2'd0;
    localparam logic [OP_W-1:0] OP_TIMER      = 2'd1;
    localparam logic [OP_W-1:0] OP_DIR_REQ    = 2'd2;

    // Roll direction codes.
    localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEATER_DUTY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TARGET = 1'd1;

    // Phase sequencer steps. Steps above STEP_LOST are the free-running
    // error range; the counter saturates at STEP_ERROR.
    localparam logic [STEP_W-1:0] STEP_GATE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_QUARTER = 4'd1;
    localparam logic [STEP_W-1:0] STEP_IGNORE  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LOST    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SYNC_LOST_MIN = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ERROR   = 4'd15;

    // Reload values for an 8-bit up counter that overflows after N ticks.
    localparam logic [BYTE_W-1:0] RELOAD_GATE =
        BYTE_W'((256 - (GATE_PULSE_TICKS & 255)) & 255);
    localparam logic [BYTE_W-1:0] RELOAD_QUARTER =
        BYTE_W'((256 - ((QUARTER_TICKS - GATE_PULSE_TICKS) & 255)) & 255);
    localparam logic [BYTE_W-1:0] RELOAD_IGNORE =
        BYTE_W'((256 - ((IGNORE_TICKS - QUARTER_TICKS) & 255)) & 255);
    localparam logic [BYTE_W-1:0] RELOAD_LOST =
        BYTE_W'((256 - (LOST_TICKS & 255)) & 255);

    localparam logic [BYTE_W-1:0] WINDOW_LAST = BYTE_W'(WINDOW_PERIODS - 1);
    localparam logic [POS_W-1:0]  POS_RESET   = 16'h8000;

endpackage

>>> src/ac_sync_triac_heater_motor_ctrl_top.sv
// ----------------------------------------------------------------------------
// ac_sync_triac_heater_motor_ctrl_top
// A transaction passes through two registers on its way to the result: the
// input register, then the result register. One transaction per cycle while
// m_axis_tready is high, set by the single combinational update between them.
// Reset: asynchronous, active low; the sequencer starts parked in the error
// step with the zero-cross detector armed and all drives off.
// ----------------------------------------------------------------------------
module ac_sync_triac_heater_motor_ctrl_top
    import acst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: direction[1:0], cycle_request[2], zero fill [7:3]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: heater_gate[0], motor_forward_drive[1], motor_reverse_drive[2],
    // timer_reload[10:3], comparator_armed[11], sync_lost[12],
    // duty_nonzero[13], heater_ready[14], rotating_forward[15],
    // rotating_reverse[16], roll_position[32:17], cycling[33], zero fill [39:34]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data
);

    // Input stage
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic              cyc_req_reg;

    // Result stage
    logic                  out_valid_reg;
    logic [OUT_USED_W-1:0] out_data_reg;
    logic [OUT_USED_W-1:0] out_data_next;

    // Configuration
    logic [BYTE_W-1:0] heater_duty_reg;
    logic [BYTE_W-1:0] cycle_target_reg;

    // Controller state
    logic [STEP_W-1:0] phase_step_reg,   phase_step_next;
    logic              half_toggle_reg,  half_toggle_next;
    logic [BYTE_W-1:0] window_count_reg, window_count_next;
    logic [BYTE_W-1:0] latched_duty_reg, latched_duty_next;
    logic [DIR_W-1:0]  roll_dir_reg,     roll_dir_next;
    logic              cycle_active_reg, cycle_active_next;
    logic [DIR_W-1:0]  applied_dir_reg,  applied_dir_next;
    logic [POS_W-1:0]  position_reg,     position_next;
    logic [POS_W-1:0]  upper_turn_reg,   upper_turn_next;
    logic [POS_W-1:0]  lower_turn_reg,   lower_turn_next;
    logic [BYTE_W-1:0] reversal_cnt_reg, reversal_cnt_next;
    logic              ready_flag_reg,   ready_flag_next;
    logic              gate_reg,         gate_next;
    logic              fwd_reg,          fwd_next;
    logic              rev_reg,          rev_next;
    logic              armed_reg,        armed_next;
    logic [BYTE_W-1:0] reload_reg,       reload_next;
    logic              rot_fwd_reg,      rot_fwd_next;
    logic              rot_rev_reg,      rot_rev_next;

    logic advance;
    logic full_period;

    // The input register moves on whenever the result register is free or
    // being emptied in the same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_data_reg};

    // A full line period completes at the quarter point of every second
    // half period.
    assign full_period = (op_reg == OP_TIMER) && half_toggle_reg &&
                         (phase_step_reg == STEP_QUARTER);

    // Phase sequencer next step.
    always_comb
    begin
        phase_step_next = phase_step_reg;
        if (op_reg == OP_ZERO_CROSS)
        begin
            if (armed_reg)
            begin
                phase_step_next = STEP_GATE;
            end
        end
        else if (op_reg == OP_TIMER)
        begin
            if (phase_step_reg != STEP_ERROR)
            begin
                phase_step_next = phase_step_reg + 1'b1;
            end
        end
    end

    // Drives, heater window and roll motion.
    always_comb
    begin
        half_toggle_next  = half_toggle_reg;
        window_count_next = window_count_reg;
        latched_duty_next = latched_duty_reg;
        roll_dir_next     = roll_dir_reg;
        cycle_active_next = cycle_active_reg;
        applied_dir_next  = applied_dir_reg;
        position_next     = position_reg;
        upper_turn_next   = upper_turn_reg;
        lower_turn_next   = lower_turn_reg;
        reversal_cnt_next = reversal_cnt_reg;
        ready_flag_next   = ready_flag_reg;
        gate_next         = gate_reg;
        fwd_next          = fwd_reg;
        rev_next          = rev_reg;
        armed_next        = armed_reg;
        reload_next       = reload_reg;
        rot_fwd_next      = rot_fwd_reg;
        rot_rev_next      = rot_rev_reg;

        unique case (op_reg)
            OP_ZERO_CROSS:
            begin
                // A crossing while disarmed is ignored.
                if (armed_reg)
                begin
                    armed_next       = 1'b0;
                    if (window_count_reg < latched_duty_reg)
                    begin
                        gate_next = 1'b1;
                    end
                    reload_next      = RELOAD_GATE;
                    half_toggle_next = !half_toggle_reg;
                end
            end
            OP_TIMER:
            begin
                unique case (phase_step_reg)
                    STEP_GATE:
                    begin
                        gate_next   = 1'b0;
                        reload_next = RELOAD_QUARTER;
                    end
                    STEP_QUARTER:
                    begin
                        reload_next = RELOAD_IGNORE;
                    end
                    STEP_IGNORE:
                    begin
                        reload_next = RELOAD_LOST;
                        armed_next  = 1'b1;
                    end
                    STEP_LOST:
                    begin
                        // Sync lost: everything off, timer free-runs.
                        gate_next         = 1'b0;
                        fwd_next          = 1'b0;
                        rev_next          = 1'b0;
                        window_count_next = '0;
                        reload_next       = '0;
                    end
                    default:
                    begin
                        reload_next = '0;
                    end
                endcase

                if (full_period)
                begin
                    fwd_next = 1'b0;
                    rev_next = 1'b0;
                    if (applied_dir_reg != roll_dir_reg)
                    begin
                        // Direction change: one dead period with no drive.
                        applied_dir_next = roll_dir_reg;
                    end
                    else
                    begin
                        fwd_next = roll_dir_reg[0];
                        rev_next = !roll_dir_reg[0] && roll_dir_reg[1];
                        if (roll_dir_reg == DIR_FORWARD)
                        begin
                            position_next = position_reg + 1'b1;
                            if (cycle_active_reg && (position_next >= upper_turn_reg))
                            begin
                                if (reversal_cnt_reg >= cycle_target_reg)
                                begin
                                    cycle_active_next = 1'b0;
                                end
                                else
                                begin
                                    reversal_cnt_next = reversal_cnt_reg + 1'b1;
                                    roll_dir_next     = DIR_REVERSE;
                                end
                            end
                        end
                        else if (roll_dir_reg == DIR_REVERSE)
                        begin
                            position_next = position_reg - 1'b1;
                            if (cycle_active_reg && (position_next <= lower_turn_reg))
                            begin
                                if (reversal_cnt_reg >= cycle_target_reg)
                                begin
                                    cycle_active_next = 1'b0;
                                end
                                else
                                begin
                                    reversal_cnt_next = reversal_cnt_reg + 1'b1;
                                    roll_dir_next     = DIR_FORWARD;
                                end
                            end
                        end
                        rot_fwd_next = roll_dir_next[0];
                        rot_rev_next = !roll_dir_next[0] && roll_dir_next[1];
                    end

                    // Burst-fire window; the new duty takes effect per window.
                    if (window_count_reg == WINDOW_LAST)
                    begin
                        window_count_next = '0;
                        latched_duty_next = heater_duty_reg;
                        ready_flag_next   = 1'b1;
                    end
                    else
                    begin
                        window_count_next = window_count_reg + 1'b1;
                    end
                end
            end
            OP_DIR_REQ:
            begin
                if (!cycle_active_reg)
                begin
                    roll_dir_next = dir_reg;
                end
                // The turn point is captured even while cycling.
                if (dir_reg[0])
                begin
                    lower_turn_next = position_reg;
                end
                else if (dir_reg[1])
                begin
                    upper_turn_next = position_reg;
                end
                if (cyc_req_reg && !cycle_active_reg &&
                    ((roll_dir_next == DIR_FORWARD) || (roll_dir_next == DIR_REVERSE)))
                begin
                    cycle_active_next = 1'b1;
                    reversal_cnt_next = '0;
                end
            end
            default:
            begin
                // Unused code: the current state is reported unchanged.
            end
        endcase
    end

    // Result fields, packed from the highest bit down.
    assign out_data_next = {
        cycle_active_next,
        position_next,
        rot_rev_next,
        rot_fwd_next,
        ready_flag_next,
        (heater_duty_reg != '0),
        (phase_step_next >= STEP_SYNC_LOST_MIN),
        armed_next,
        reload_next,
        rev_next,
        fwd_next,
        gate_next
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            heater_duty_reg  <= '0;
            cycle_target_reg <= '0;
            phase_step_reg   <= STEP_ERROR;
            half_toggle_reg  <= 1'b0;
            window_count_reg <= '0;
            latched_duty_reg <= '0;
            roll_dir_reg     <= DIR_STOP;
            cycle_active_reg <= 1'b0;
            applied_dir_reg  <= DIR_STOP;
            position_reg     <= POS_RESET;
            upper_turn_reg   <= '0;
            lower_turn_reg   <= '0;
            reversal_cnt_reg <= '0;
            ready_flag_reg   <= 1'b0;
            gate_reg         <= 1'b0;
            fwd_reg          <= 1'b0;
            rev_reg          <= 1'b0;
            armed_reg        <= 1'b1;
            reload_reg       <= '0;
            rot_fwd_reg      <= 1'b0;
            rot_rev_reg      <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_step_reg   <= phase_step_next;
                half_toggle_reg  <= half_toggle_next;
                window_count_reg <= window_count_next;
                latched_duty_reg <= latched_duty_next;
                roll_dir_reg     <= roll_dir_next;
                cycle_active_reg <= cycle_active_next;
                applied_dir_reg  <= applied_dir_next;
                position_reg     <= position_next;
                upper_turn_reg   <= upper_turn_next;
                lower_turn_reg   <= lower_turn_next;
                reversal_cnt_reg <= reversal_cnt_next;
                ready_flag_reg   <= ready_flag_next;
                gate_reg         <= gate_next;
                fwd_reg          <= fwd_next;
                rev_reg          <= rev_next;
                armed_reg        <= armed_next;
                reload_reg       <= reload_next;
                rot_fwd_reg      <= rot_fwd_next;
                rot_rev_reg      <= rot_rev_next;
            end

            // Write only while idle (unenforced); duty writes clear ready flag.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HEATER_DUTY:
                    begin
                        heater_duty_reg <= cfg_data;
                        ready_flag_reg  <= 1'b0;
                    end
                    CFG_CYCLE_TARGET:
                    begin
                        cycle_target_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg      <= s_axis_tuser;
            dir_reg     <= s_axis_tdata[DIR_W-1:0];
            cyc_req_reg <= s_axis_tdata[DIR_W];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
